// ===== hw/rtl/sudsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sudsp_pkg;

    // user data store bounds
    localparam int MAX_USER_BYTES = 40;
    localparam int CNT_W          = $clog2(MAX_USER_BYTES + 1);
    localparam int USER_AW        = $clog2(MAX_USER_BYTES);

    // inserted payload: type byte, size byte, uuid, then user bytes
    localparam int UUID_LEN = 16;
    localparam int HDR_LEN  = 2 + UUID_LEN;
    localparam int IDX_W    = $clog2(MAX_USER_BYTES + HDR_LEN);

    localparam logic [7:0] SEI_TYPE_UNREG = 8'h05;
    localparam logic [7:0] SIZE_BIAS      = 8'(UUID_LEN);

    // five-byte match window
    localparam logic [39:0] START_KEY = 40'h00_0000_0106;
    localparam logic [39:0] END_KEY   = 40'h80_0000_0001;

    localparam logic [7:0] UUID_BYTES [UUID_LEN] = '{
        8'h3A, 8'hF2, 8'h44, 8'h65, 8'hD0, 8'hCA, 8'h12, 8'h33,
        8'h2E, 8'h92, 8'h01, 8'h87, 8'h23, 8'h1B, 8'h00, 8'hFE
    };

    typedef enum logic [1:0] {
        MODE_SEEK,
        MODE_WATCH,
        MODE_DONE
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_PASS,
        ST_FLUSH
    } state_t;

    // where the next output byte comes from
    typedef enum logic [1:0] {
        SRC_DIRECT,
        SRC_INS,
        SRC_PASS,
        SRC_FLUSH
    } src_t;

    typedef struct packed {
        logic accept;
        logic emit;
        src_t src;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic stream;
        logic insert;
        logic pass;
        logic eob;
        logic eob_reg;
        logic ins_last;
        logic flush_last;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sudsp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sudsp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire sudsp_pkg::status_t status,
    output sudsp_pkg::cmd_t        cmd
);
    import sudsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready && status.stream) begin
                    if (status.insert) begin
                        state_next = ST_INS;
                    end else if (status.eob) begin
                        state_next = status.pass ? ST_PASS : ST_FLUSH;
                    end
                end
            end
            ST_INS: begin
                if (status.out_free && status.ins_last) begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS: begin
                if (status.out_free) begin
                    state_next = status.eob_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (status.out_free && status.flush_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        cmd.src    = SRC_DIRECT;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = status.out_free;
                cmd.accept = s_tvalid && status.out_free;
                cmd.emit   = cmd.accept && status.stream && status.pass &&
                             !status.insert && !status.eob;
                cmd.src    = SRC_DIRECT;
            end
            ST_INS: begin
                cmd.emit = status.out_free;
                cmd.src  = SRC_INS;
            end
            ST_PASS: begin
                cmd.emit = status.out_free;
                cmd.src  = SRC_PASS;
            end
            ST_FLUSH: begin
                cmd.emit = status.out_free;
                cmd.src  = SRC_FLUSH;
            end
            default: begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sudsp_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sudsp_dpath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser,
    input  wire sudsp_pkg::cmd_t   cmd,
    output sudsp_pkg::status_t     status
);
    import sudsp_pkg::*;

    logic [39:0]        history_reg;
    logic [2:0]         held_reg;
    mode_t              mode_reg;
    logic [2:0]         since_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               eob_reg;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic               m_tlast_reg;
    logic               m_tuser_reg;
    logic [7:0]         rd_data_reg;

    logic [7:0]         user_mem [MAX_USER_BYTES];

    logic [39:0]        hist_next;
    logic [2:0]         n;
    logic               pass;
    logic [2:0]         since_inc;
    logic               end_hit;
    logic               start_hit;
    logic               out_free;
    logic               ins_adv;
    logic               flush_adv;
    logic [IDX_W-1:0]   idx_next;
    logic [USER_AW-1:0] rd_addr;
    logic [1:0]         flush_sel;
    logic [3:0]         uuid_sel;
    logic [7:0]         out_byte;
    logic               out_last;
    logic               out_ins;

    // window compare on the byte being accepted
    always_comb begin
        hist_next = {history_reg[31:0], s_tdata};
        n         = held_reg + 3'd1;
        pass      = (n == 3'd5);
        since_inc = (since_reg < 3'd5) ? since_reg + 3'd1 : since_reg;
        end_hit   = (mode_reg == MODE_WATCH) && pass && (since_inc == 3'd5) &&
                    (hist_next == END_KEY);
        start_hit = (mode_reg == MODE_SEEK) && pass && (hist_next == START_KEY);
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign ins_adv   = cmd.emit && (cmd.src == SRC_INS);
    assign flush_adv = cmd.emit && (cmd.src == SRC_FLUSH);

    assign status.out_free   = out_free;
    assign status.stream     = s_tuser;
    assign status.insert     = end_hit && (count_reg != '0);
    assign status.pass       = pass;
    assign status.eob        = s_tlast;
    assign status.eob_reg    = eob_reg;
    assign status.ins_last   = (idx_reg == IDX_W'(count_reg) + IDX_W'(HDR_LEN - 1));
    assign status.flush_last = (held_reg == 3'd1);

    // stream state and store count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg <= '0;
            held_reg    <= '0;
            mode_reg    <= MODE_SEEK;
            since_reg   <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            eob_reg     <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (s_tuser) begin
                    history_reg <= hist_next;
                    held_reg    <= pass ? 3'd4 : n;
                    idx_reg     <= '0;
                    eob_reg     <= s_tlast;
                    unique case (mode_reg)
                        MODE_WATCH: begin
                            since_reg <= since_inc;
                            if (end_hit) begin
                                mode_reg <= MODE_DONE;
                            end
                        end
                        MODE_SEEK: begin
                            if (start_hit) begin
                                mode_reg  <= MODE_WATCH;
                                since_reg <= '0;
                            end
                        end
                        default: begin
                            mode_reg <= mode_reg;
                        end
                    endcase
                end else if (count_reg < CNT_W'(MAX_USER_BYTES)) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (ins_adv) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (flush_adv) begin
                held_reg <= held_reg - 3'd1;
                if (held_reg == 3'd1) begin
                    history_reg <= '0;
                    mode_reg    <= MODE_SEEK;
                    since_reg   <= '0;
                    count_reg   <= '0;
                end
            end
        end
    end

    // user store, read one step ahead so data is ready at each insert index
    assign idx_next = cmd.accept ? '0 : (ins_adv ? idx_reg + IDX_W'(1) : idx_reg);
    assign rd_addr  = USER_AW'(idx_next - IDX_W'(HDR_LEN));

    always_ff @(posedge aclk) begin
        if (cmd.accept && !s_tuser && (count_reg < CNT_W'(MAX_USER_BYTES))) begin
            user_mem[count_reg[USER_AW-1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if ({1'b0, rd_addr} < (USER_AW + 1)'(MAX_USER_BYTES)) begin
            rd_data_reg <= user_mem[rd_addr];
        end
    end

    // output byte select
    assign flush_sel = 2'(held_reg - 3'd1);
    assign uuid_sel  = 4'(idx_reg - IDX_W'(2));

    always_comb begin
        out_byte = hist_next[39:32];
        out_last = 1'b0;
        out_ins  = 1'b0;
        unique case (cmd.src)
            SRC_DIRECT: begin
                out_byte = hist_next[39:32];
            end
            SRC_PASS: begin
                out_byte = history_reg[39:32];
            end
            SRC_FLUSH: begin
                out_byte = history_reg[flush_sel*8 +: 8];
                out_last = (held_reg == 3'd1);
            end
            SRC_INS: begin
                out_ins = 1'b1;
                if (idx_reg == '0) begin
                    out_byte = SEI_TYPE_UNREG;
                end else if (idx_reg == IDX_W'(1)) begin
                    out_byte = 8'(count_reg) + SIZE_BIAS;
                end else if (idx_reg < IDX_W'(HDR_LEN)) begin
                    out_byte = UUID_BYTES[uuid_sel];
                end else begin
                    out_byte = rd_data_reg;
                end
            end
            default: begin
                out_byte = hist_next[39:32];
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= out_byte;
            m_tlast_reg <= out_last;
            m_tuser_reg <= out_ins;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sei_user_data_splicer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// sei user data splicer
// input stream: s_tuser selects the kind of transaction (0 loads a user byte into
// the store, 1 is an elementary stream byte), s_tdata carries the byte and s_tlast
// marks the final stream byte of an access unit buffer
// output stream: spliced bytes on m_tdata, m_tlast on the final byte of the buffer,
// m_tuser high on bytes of the inserted sei payload
// stream bytes pass through a four-byte hold window; each stream transaction past
// the fourth of a buffer releases one byte into the output register
// throughput: one transaction per cycle while the receiver keeps up and no insertion
// or flush is running; at the end key, with user bytes stored, the block emits the
// payload of 18 + user count bytes, then the held byte; at end of buffer a full
// window first releases its oldest byte, then up to four held bytes are flushed
// in these bursts s_tready stays low; the payload rate is set by the output register
// reset clears the window, the search state and the user count (store holds no
// valid entries until loaded)
// when the receiver stalls, the result waits in the output register and s_tready
// drops until that register is taken
module sei_user_data_splicer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_buffer
    input  wire logic       s_tuser,   // [0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // out_last
    output logic            m_tuser    // [0] out_inserted
);
    import sudsp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // controller sequences payload, held byte and flush
    sudsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: window, key match, user store and output register
    sudsp_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    // a new byte never overwrites a result still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("emit while output register is occupied");

    // the final flush byte carries tlast
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (cmd.src == SRC_FLUSH) && status.flush_last) |=> m_tlast)
        else $error("final flush byte lost tlast");

    // an insertion holds off the input side
    a_insert_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.stream && status.insert) |=> !s_tready)
        else $error("input accepted during insertion");

    // inserted bytes are flagged in m_tuser
    a_ins_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (cmd.src == SRC_INS)) |=> (m_tvalid && m_tuser))
        else $error("inserted byte not flagged");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sudsp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_LIMIT   = 1000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 10;

    localparam bit OP_LOAD   = 1'b0;
    localparam bit OP_STREAM = 1'b1;

    localparam logic [7:0]  PAYLOAD_TYPE = 8'h05;
    localparam logic [7:0]  SIZE_OFFSET  = 8'd16;
    localparam logic [39:0] KEY_START    = 40'h00_0000_0106;
    localparam logic [39:0] KEY_END      = 40'h80_0000_0001;
    localparam logic [7:0]  SEI_UUID [16] = '{
        8'h3A, 8'hF2, 8'h44, 8'h65, 8'hD0, 8'hCA, 8'h12, 8'h33,
        8'h2E, 8'h92, 8'h01, 8'h87, 8'h23, 8'h1B, 8'h00, 8'hFE
    };

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ins;
    } spliced_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // splicer model state
    logic [39:0]  win_hist;
    int unsigned  held_bytes;
    mode_t        key_mode;
    int unsigned  since_start;
    logic [7:0]   user_bytes [MAX_USER_BYTES];
    int unsigned  user_len;

    spliced_byte_t spliced_due [$];   // expected output bytes, oldest first

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  idle_cycles = 0;
    bit  tx_no_idle  = 1'b0;
    bit  rx_no_idle  = 1'b0;
    bit  sink_hold_req = 1'b0;

    sei_user_data_splicer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic void due_push(logic [7:0] d, bit last, bit ins);
        spliced_byte_t e;
        e.data = d;
        e.last = last;
        e.ins  = ins;
        spliced_due.push_back(e);
    endfunction

    function automatic void splice_clear_window();
        win_hist    = '0;
        held_bytes  = 0;
        key_mode    = MODE_SEEK;
        since_start = 0;
    endfunction

    // expected output bytes caused by one accepted input transaction
    function automatic void splice_predict(bit op, logic [7:0] b, bit eob);
        int unsigned n;
        if (op == OP_LOAD) begin
            // store full drops the byte, and tlast on a load means nothing
            if (user_len < MAX_USER_BYTES) begin
                user_bytes[user_len] = b;
                user_len++;
            end
            return;
        end
        win_hist = {win_hist[31:0], b};
        n = held_bytes + 1;
        if (key_mode == MODE_WATCH) begin
            if (since_start < 5)
                since_start++;
            if (n == 5 && since_start >= 5 && win_hist == KEY_END) begin
                // payload goes out ahead of the 0x80 of the end key
                if (user_len > 0) begin
                    due_push(PAYLOAD_TYPE, 1'b0, 1'b1);
                    due_push(8'(user_len) + SIZE_OFFSET, 1'b0, 1'b1);
                    for (int i = 0; i < 16; i++)
                        due_push(SEI_UUID[i], 1'b0, 1'b1);
                    for (int i = 0; i < user_len; i++)
                        due_push(user_bytes[i], 1'b0, 1'b1);
                end
                key_mode = MODE_DONE;
            end
        end else if (key_mode == MODE_SEEK && n == 5 && win_hist == KEY_START) begin
            key_mode    = MODE_WATCH;
            since_start = 0;
        end
        if (n >= 5) begin
            due_push(win_hist[39:32], 1'b0, 1'b0);
            n = 4;
        end
        held_bytes = n;
        if (eob) begin
            while (n > 0) begin
                n--;
                due_push(win_hist[8*n +: 8], n == 0, 1'b0);
            end
            splice_clear_window();
            user_len = 0;
        end
    endfunction

    // one input transaction, with a random gap in front of it
    task automatic send_item(bit op, logic [7:0] b, bit eob);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        s_tlast  <= eob;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if (op == OP_STREAM || user_len < MAX_USER_BYTES)
            items_sent++;
        splice_predict(op, b, eob);
    endtask

    // stream bytes of one buffer, tlast on the final one; loads may be mixed in
    task automatic send_buffer(byte_q_t seq, bit mix_loads);
        for (int i = 0; i < seq.size(); i++) begin
            if (mix_loads && $urandom_range(0, 9) == 0)
                send_item(OP_LOAD, 8'($urandom), 1'($urandom));
            send_item(OP_STREAM, seq[i], i == seq.size() - 1);
        end
    endtask

    task automatic load_user_bytes(int count);
        for (int i = 0; i < count; i++)
            send_item(OP_LOAD, 8'($urandom), $urandom_range(0, 5) == 0);
    endtask

    // bytes that often form key fragments
    function automatic logic [7:0] key_biased_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h06;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // short buffers never fill the window, even when the history spells a key
    task automatic test_short_buffers();
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        send_buffer('{8'hFF, 8'h00, 8'h80}, 1'b0);
        send_buffer('{8'h01, 8'h06}, 1'b0);
        send_buffer('{8'h7E}, 1'b0);
        // load with tlast set: byte kept, flag ignored
        send_item(OP_LOAD, 8'hA5, 1'b1);
    endtask

    // start key followed at once by the end key, with user bytes stored
    task automatic test_insertion();
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        send_item(OP_LOAD, 8'h00, 1'b0);
        send_item(OP_LOAD, 8'hFF, 1'b0);
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
                      8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h11}, 1'b0);
    endtask

    // end key seen with an empty store: nothing inserted
    task automatic test_empty_store();
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
                      8'h80, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
    endtask

    // more loads than the store holds, then the largest payload
    task automatic test_store_full();
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b0;
        load_user_bytes(MAX_USER_BYTES + 3);
        send_buffer('{8'hC3, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06, 8'h55, 8'h80,
                      8'h00, 8'h00, 8'h00, 8'h01, 8'hFE, 8'h3C}, 1'b0);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        byte_q_t seq;
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        for (int i = 0; i < 12; i++)
            seq.push_back(8'($urandom));
        sink_hold_req = 1'b1;
        send_buffer(seq, 1'b0);
    endtask

    task automatic random_frame();
        byte_q_t seq;
        int      n_loads;
        n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 44) : $urandom_range(0, 6);
        tx_no_idle = $urandom_range(0, 3) == 0;
        rx_no_idle = $urandom_range(0, 3) == 0;
        load_user_bytes(n_loads);
        if ($urandom_range(0, 3) != 0) begin
            // buffer with random filler around the two keys, either of which may be malformed
            repeat ($urandom_range(0, 3)) seq.push_back(key_biased_byte());
            if ($urandom_range(0, 7) == 0)
                seq = {seq, 8'h00, 8'h00, 8'h01, 8'h06};  // broken start key
            else
                seq = {seq, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06};
            repeat ($urandom_range(0, 6)) seq.push_back(key_biased_byte());
            if ($urandom_range(0, 5) == 0)
                seq = {seq, 8'h80, 8'h00, 8'h00, 8'h00};   // end key cut short
            else
                seq = {seq, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01};
            repeat ($urandom_range(0, 4)) seq.push_back(key_biased_byte());
        end else begin
            repeat ($urandom_range(1, 12)) seq.push_back(key_biased_byte());
        end
        send_buffer(seq, 1'b1);
    endtask

    task automatic test_random();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
            random_frame();
    endtask

    // receiver: random hold-off before each output transaction
    initial begin : sink
        int w;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (sink_hold_req) begin
                w = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end else begin
                w = rx_no_idle ? 0 : $urandom_range(0, 16);
            end
            repeat (w) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge aclk) begin
        spliced_byte_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (spliced_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output byte, expected none, actual %h last %b ins %b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                e = spliced_due.pop_front();
                if (m_tdata !== e.data) begin
                    mismatches++;
                    $display("%0t: out_byte expected %h actual %h", $time, e.data, m_tdata);
                end
                if (m_tlast !== e.last) begin
                    mismatches++;
                    $display("%0t: out_last expected %b actual %b", $time, e.last, m_tlast);
                end
                if (m_tuser !== e.ins) begin
                    mismatches++;
                    $display("%0t: out_inserted expected %b actual %b", $time, e.ins, m_tuser);
                end
            end
        end
    end

    // watchdog: too long with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        s_tuser  = OP_LOAD;
        splice_clear_window();
        user_len = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_short_buffers();
        test_insertion();
        test_empty_store();
        test_store_full();
        test_backpressure();
        test_random();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (spliced_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
